FILE: hw/rtl/sample_offset_dedupe_table_defines.svh
// Assertion macros for the checker file.
`ifndef SAMPLE_OFFSET_DEDUPE_TABLE_DEFINES_SVH
`define SAMPLE_OFFSET_DEDUPE_TABLE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SODT_AST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define SODT_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sodt_pkg.sv
package sodt_pkg;

  localparam int DEF_CHANNELS = 8;
  localparam int DEF_ENTRIES  = 64;
  localparam int DEF_SAMPLES  = 32;

  localparam int OP_W    = 1;
  localparam int CHAN_W  = 3;
  localparam int SNUM_W  = 5;
  localparam int PARAM_W = 8;
  localparam int LEN_W   = 17;
  localparam int CFG_W   = 7;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;
  localparam logic [OP_W-1:0]  OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0]  OP_CELL = 1'b1;
  localparam logic [LEN_W-1:0] LOOP_MIN_LEN = 17'd2;

  typedef struct packed {
    logic [SNUM_W-1:0]  active_sample;
    logic [PARAM_W-1:0] offset_mem;
  } chan_rec_t;

  typedef struct packed {
    logic [LEN_W-1:0] used_len;
    logic [LEN_W-1:0] loop_begin;
    logic [LEN_W-1:0] loop_size;
  } desc_t;

  typedef struct packed {
    logic [SNUM_W-1:0]  sample;
    logic [PARAM_W-1:0] param;
  } key_t;

endpackage

FILE: hw/rtl/sample_offset_dedupe_table.sv
// Flow (transfer in to result valid): a descriptor load goes to OUT, a plain cell
// through CHAN to OUT, an offset cell through CHAN and SCAN to OUT on a hit, or
// through FILL and MAKE when an entry is created. Throughput: one item at a time; an
// offset cell holds the block through the key memory scan at one entry per cycle.
// Reset: channel records read as zero, entry count 0, capacity 64; key and
// descriptor memories are not cleared, so the block is ready right after reset.
module sample_offset_dedupe_table
  import sodt_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int SAMPLES  = DEF_SAMPLES
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_max_entries,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  logic [CHAN_W-1:0]  in_channel,
  input  logic [SNUM_W-1:0]  in_sample_number,
  input  logic               in_is_offset_effect,
  input  logic [PARAM_W-1:0] in_offset_param,
  input  logic [LEN_W-1:0]   in_used_length,
  input  logic [LEN_W-1:0]   in_loop_begin,
  input  logic [LEN_W-1:0]   in_loop_size,

  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_subsample,
  output logic [PARAM_W-1:0] out_param,
  output logic               out_new_entry,
  output logic [SNUM_W-1:0]  out_entry_sample,
  output logic [LEN_W-1:0]   out_entry_start,
  output logic [LEN_W-1:0]   out_entry_length,
  output logic [LEN_W-1:0]   out_entry_loop_start,
  output logic [LEN_W-1:0]   out_entry_loop_length
);

  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int SW  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHAN = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_FILL = 3'd3;
  localparam logic [2:0] ST_MAKE = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   max_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [EW-1:0]      scan_idx_r, scan_idx_nxt;

  logic               chan_ok_r;
  logic [CHW-1:0]     ch_addr_r;
  logic [SNUM_W-1:0]  snum_r;
  logic               is_off_r;
  logic [PARAM_W-1:0] param_r;
  logic [SNUM_W-1:0]  sample_r, sample_nxt;
  logic [PARAM_W-1:0] rparam_r, rparam_nxt;
  logic               samp_ok_r, samp_ok_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;

  logic               res_sub_r, res_sub_nxt;
  logic [PARAM_W-1:0] res_param_r, res_param_nxt;
  logic               res_new_r, res_new_nxt;
  logic [SNUM_W-1:0]  res_sample_r, res_sample_nxt;
  logic [LEN_W-1:0]   res_start_r, res_start_nxt;
  logic [LEN_W-1:0]   res_len_r, res_len_nxt;
  logic [LEN_W-1:0]   res_lstart_r, res_lstart_nxt;
  logic [LEN_W-1:0]   res_llen_r, res_llen_nxt;

  logic               out_valid_r;
  logic               out_sub_r;
  logic [PARAM_W-1:0] out_param_r;
  logic               out_new_r;
  logic [SNUM_W-1:0]  out_sample_r;
  logic [LEN_W-1:0]   out_start_r;
  logic [LEN_W-1:0]   out_len_r;
  logic [LEN_W-1:0]   out_lstart_r;
  logic [LEN_W-1:0]   out_llen_r;

  logic               in_xfer;
  logic               out_free;
  logic               out_load;

  logic               chan_rd_en;
  chan_rec_t          chan_rd;
  logic               chan_wr_en;
  chan_rec_t          chan_wr;

  logic               key_rd_en;
  logic [EW-1:0]      key_rd_addr;
  key_t               key_rd;
  logic               key_wr_en;
  key_t               key_wr;
  logic               key_hit;

  logic               desc_rd_en;
  logic               desc_wr_en;
  desc_t              desc_wr;
  desc_t              desc_rd;
  logic [LEN_W-1:0]   d_used;
  logic [LEN_W-1:0]   d_lbeg;
  logic [LEN_W-1:0]   d_lsize;
  logic [LEN_W-1:0]   base_len;
  logic               table_full;
  logic               loop_clear;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = (state_r == ST_OUT) && out_free;

  assign chan_rd_en = in_xfer;
  assign desc_wr_en = in_xfer && (in_op == OP_LOAD) && (int'(in_sample_number) < SAMPLES);
  assign desc_wr    = '{used_len: in_used_length, loop_begin: in_loop_begin,
                        loop_size: in_loop_size};

  sodt_chan_mem #(.CHANNELS(CHANNELS), .CHW(CHW)) u_chan_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (chan_rd_en),
    .rd_addr (CHW'(in_channel)),
    .rd_data (chan_rd),
    .wr_en   (chan_wr_en),
    .wr_addr (ch_addr_r),
    .wr_data (chan_wr)
  );

  sodt_key_mem #(.ENTRIES(ENTRIES), .EW(EW)) u_key_mem (
    .clk     (clk),
    .rd_en   (key_rd_en),
    .rd_addr (key_rd_addr),
    .rd_key  (key_rd),
    .wr_en   (key_wr_en),
    .wr_addr (EW'(count_r)),
    .wr_key  (key_wr)
  );

  sodt_desc_mem #(.SAMPLES(SAMPLES), .SW(SW)) u_desc_mem (
    .clk     (clk),
    .rd_en   (desc_rd_en),
    .rd_addr (SW'(sample_nxt)),
    .rd_data (desc_rd),
    .wr_en   (desc_wr_en),
    .wr_addr (SW'(in_sample_number)),
    .wr_data (desc_wr)
  );

  assign key_hit  = (key_rd.sample == sample_r) && (key_rd.param == rparam_r);
  assign key_wr   = '{sample: sample_r, param: rparam_r};

  assign d_used   = samp_ok_r ? desc_rd.used_len   : '0;
  assign d_lbeg   = samp_ok_r ? desc_rd.loop_begin : '0;
  assign d_lsize  = samp_ok_r ? desc_rd.loop_size  : '0;
  assign base_len = {1'b0, rparam_r, 8'h00};

  assign table_full = (int'(count_r) >= int'(max_r)) || (int'(count_r) >= ENTRIES);
  assign loop_clear = (d_lsize <= LOOP_MIN_LEN) || (len_r > d_lbeg);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    sample_nxt     = sample_r;
    rparam_nxt     = rparam_r;
    samp_ok_nxt    = samp_ok_r;
    len_nxt        = len_r;
    res_sub_nxt    = res_sub_r;
    res_param_nxt  = res_param_r;
    res_new_nxt    = res_new_r;
    res_sample_nxt = res_sample_r;
    res_start_nxt  = res_start_r;
    res_len_nxt    = res_len_r;
    res_lstart_nxt = res_lstart_r;
    res_llen_nxt   = res_llen_r;
    chan_wr_en     = 1'b0;
    chan_wr        = chan_rd;
    key_rd_en      = 1'b0;
    key_rd_addr    = EW'(scan_idx_r + EW'(1));
    key_wr_en      = 1'b0;
    desc_rd_en     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          res_sub_nxt    = 1'b0;
          res_new_nxt    = 1'b0;
          res_sample_nxt = '0;
          res_start_nxt  = '0;
          res_len_nxt    = '0;
          res_lstart_nxt = '0;
          res_llen_nxt   = '0;
          if (in_op == OP_LOAD) begin
            res_param_nxt = '0;
            state_nxt     = ST_OUT;
          end else begin
            res_param_nxt = in_offset_param;
            state_nxt     = ST_CHAN;
          end
        end
      end
      ST_CHAN: begin
        sample_nxt = (snum_r != '0) ? (snum_r - SNUM_W'(1)) : chan_rd.active_sample;
        rparam_nxt = (param_r != '0) ? param_r : chan_rd.offset_mem;
        chan_wr.active_sample = sample_nxt;
        chan_wr.offset_mem    = is_off_r ? rparam_nxt : chan_rd.offset_mem;
        chan_wr_en = chan_ok_r;
        if (chan_ok_r && is_off_r) begin
          res_param_nxt = rparam_nxt;
          samp_ok_nxt   = int'(sample_nxt) < SAMPLES;
          desc_rd_en    = 1'b1;
          if (count_r == '0) begin
            state_nxt = ST_FILL;
          end else begin
            key_rd_en    = 1'b1;
            key_rd_addr  = '0;
            scan_idx_nxt = '0;
            state_nxt    = ST_SCAN;
          end
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_SCAN: begin
        if (key_hit) begin
          res_sub_nxt   = 1'b1;
          res_param_nxt = PARAM_W'(scan_idx_r);
          state_nxt     = ST_OUT;
        end else if (CW'(scan_idx_r) + CW'(1) == count_r) begin
          state_nxt = ST_FILL;
        end else begin
          key_rd_en    = 1'b1;
          scan_idx_nxt = scan_idx_r + EW'(1);
        end
      end
      ST_FILL: begin
        if (table_full) begin
          state_nxt = ST_OUT;
        end else begin
          len_nxt        = (base_len > d_used) ? d_used : base_len;
          key_wr_en      = 1'b1;
          count_nxt      = count_r + CW'(1);
          res_sub_nxt    = 1'b1;
          res_param_nxt  = PARAM_W'(count_r);
          res_new_nxt    = 1'b1;
          res_sample_nxt = sample_r;
          state_nxt      = ST_MAKE;
        end
      end
      ST_MAKE: begin
        res_start_nxt  = len_r;
        res_len_nxt    = d_used - len_r;
        res_lstart_nxt = loop_clear ? '0 : (d_lbeg - len_r);
        res_llen_nxt   = loop_clear ? '0 : d_lsize;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_r       <= MAX_ENTRIES_RST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_max_entries;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      chan_ok_r <= int'(in_channel) < CHANNELS;
      ch_addr_r <= CHW'(in_channel);
      snum_r    <= in_sample_number;
      is_off_r  <= in_is_offset_effect;
      param_r   <= in_offset_param;
    end
    scan_idx_r   <= scan_idx_nxt;
    sample_r     <= sample_nxt;
    rparam_r     <= rparam_nxt;
    samp_ok_r    <= samp_ok_nxt;
    len_r        <= len_nxt;
    res_sub_r    <= res_sub_nxt;
    res_param_r  <= res_param_nxt;
    res_new_r    <= res_new_nxt;
    res_sample_r <= res_sample_nxt;
    res_start_r  <= res_start_nxt;
    res_len_r    <= res_len_nxt;
    res_lstart_r <= res_lstart_nxt;
    res_llen_r   <= res_llen_nxt;
    if (out_load) begin
      out_sub_r    <= res_sub_r;
      out_param_r  <= res_param_r;
      out_new_r    <= res_new_r;
      out_sample_r <= res_sample_r;
      out_start_r  <= res_start_r;
      out_len_r    <= res_len_r;
      out_lstart_r <= res_lstart_r;
      out_llen_r   <= res_llen_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_is_subsample      = out_sub_r;
  assign out_param             = out_param_r;
  assign out_new_entry         = out_new_r;
  assign out_entry_sample      = out_sample_r;
  assign out_entry_start       = out_start_r;
  assign out_entry_length      = out_len_r;
  assign out_entry_loop_start  = out_lstart_r;
  assign out_entry_loop_length = out_llen_r;

endmodule

FILE: hw/rtl/sodt_chan_mem.sv
module sodt_chan_mem
  import sodt_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rd_en,
  input  logic [CHW-1:0] rd_addr,
  output chan_rec_t      rd_data,
  input  logic           wr_en,
  input  logic [CHW-1:0] wr_addr,
  input  chan_rec_t      wr_data
);

  chan_rec_t            mem [CHANNELS];
  logic [CHANNELS-1:0]  vld_r;
  chan_rec_t            rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // unwritten channel reads as reset value
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: hw/rtl/sodt_key_mem.sv
module sodt_key_mem
  import sodt_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [EW-1:0] rd_addr,
  output key_t          rd_key,
  input  logic          wr_en,
  input  logic [EW-1:0] wr_addr,
  input  key_t          wr_key
);

  key_t mem [ENTRIES];
  key_t rd_key_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_key;
    end
    if (rd_en) begin
      rd_key_r <= mem[rd_addr];
    end
  end

  assign rd_key = rd_key_r;

endmodule

FILE: hw/rtl/sodt_desc_mem.sv
module sodt_desc_mem
  import sodt_pkg::*;
#(
  parameter int SAMPLES = DEF_SAMPLES,
  parameter int SW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [SW-1:0] rd_addr,
  output desc_t         rd_data,
  input  logic          wr_en,
  input  logic [SW-1:0] wr_addr,
  input  desc_t         wr_data
);

  desc_t mem [SAMPLES];
  desc_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/sodt_checker.sv
`include "sample_offset_dedupe_table_defines.svh"

module sodt_checker
  import sodt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_is_subsample,
  input logic [PARAM_W-1:0] out_param,
  input logic               out_new_entry,
  input logic [SNUM_W-1:0]  out_entry_sample,
  input logic [LEN_W-1:0]   out_entry_start,
  input logic [LEN_W-1:0]   out_entry_length,
  input logic [LEN_W-1:0]   out_entry_loop_start,
  input logic [LEN_W-1:0]   out_entry_loop_length
);

  `SODT_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_param) && $stable(out_new_entry), "result changed while stalled")
  `SODT_AST_IMPLY(a_new_is_sub, out_valid && out_new_entry, out_is_subsample, "new entry without subsample rewrite")
  `SODT_AST_IMPLY(a_no_new_zero, out_valid && !out_new_entry, out_entry_sample == '0 && out_entry_start == '0 && out_entry_length == '0 && out_entry_loop_start == '0 && out_entry_loop_length == '0, "entry fields set without new entry")
  `SODT_AST_IMPLY(a_loop_len, out_valid && out_new_entry && out_entry_loop_length != '0, out_entry_loop_length > LOOP_MIN_LEN, "short loop not cleared")

endmodule

bind sample_offset_dedupe_table sodt_checker u_sodt_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sodt_pkg::*;

  localparam int LEN_MAX     = (1 << LEN_W) - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 166;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CHAN_W-1:0]  channel;
    logic [SNUM_W-1:0]  sample_number;
    logic               is_offset_effect;
    logic [PARAM_W-1:0] offset_param;
    logic [LEN_W-1:0]   used_len;
    logic [LEN_W-1:0]   loop_begin;
    logic [LEN_W-1:0]   loop_size;
    logic [6:0]         gap_pct;
    logic [6:0]         stall_pct;
  } cell_item_t;

  typedef struct packed {
    logic               is_subsample;
    logic [PARAM_W-1:0] param;
    logic               new_entry;
    logic [SNUM_W-1:0]  sample;
    logic [LEN_W-1:0]   start;
    logic [LEN_W-1:0]   length;
    logic [LEN_W-1:0]   lp_start;
    logic [LEN_W-1:0]   lp_len;
  } entry_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_max_entries = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_op = '0;
  logic [CHAN_W-1:0]  in_channel = '0;
  logic [SNUM_W-1:0]  in_sample_number = '0;
  logic               in_is_offset_effect = 1'b0;
  logic [PARAM_W-1:0] in_offset_param = '0;
  logic [LEN_W-1:0]   in_used_length = '0;
  logic [LEN_W-1:0]   in_loop_begin = '0;
  logic [LEN_W-1:0]   in_loop_size = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_is_subsample;
  logic [PARAM_W-1:0] out_param;
  logic               out_new_entry;
  logic [SNUM_W-1:0]  out_entry_sample;
  logic [LEN_W-1:0]   out_entry_start;
  logic [LEN_W-1:0]   out_entry_length;
  logic [LEN_W-1:0]   out_entry_loop_start;
  logic [LEN_W-1:0]   out_entry_loop_length;

  sample_offset_dedupe_table u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_max_entries       (cfg_max_entries),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_channel            (in_channel),
    .in_sample_number      (in_sample_number),
    .in_is_offset_effect   (in_is_offset_effect),
    .in_offset_param       (in_offset_param),
    .in_used_length        (in_used_length),
    .in_loop_begin         (in_loop_begin),
    .in_loop_size          (in_loop_size),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_is_subsample      (out_is_subsample),
    .out_param             (out_param),
    .out_new_entry         (out_new_entry),
    .out_entry_sample      (out_entry_sample),
    .out_entry_start       (out_entry_start),
    .out_entry_length      (out_entry_length),
    .out_entry_loop_start  (out_entry_loop_start),
    .out_entry_loop_length (out_entry_loop_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cell_item_t    pending_cells[$];
  entry_result_t expected_results[$];
  int            fail_count = 0;
  int            cycle_count = 0;
  logic [6:0]    stall_pct = '0;

  logic [SNUM_W-1:0]  chan_sample [DEF_CHANNELS];
  logic [PARAM_W-1:0] chan_offset [DEF_CHANNELS];
  logic [SNUM_W-1:0]  key_sample [DEF_ENTRIES];
  logic [PARAM_W-1:0] key_param [DEF_ENTRIES];
  int                 key_count;
  logic [LEN_W-1:0]   desc_used [DEF_SAMPLES];
  logic [LEN_W-1:0]   desc_loop_begin [DEF_SAMPLES];
  logic [LEN_W-1:0]   desc_loop_size [DEF_SAMPLES];
  logic [CFG_W-1:0]   capacity = MAX_ENTRIES_RST;
  bit [DEF_SAMPLES-1:0] desc_loaded = '0;

  function automatic entry_result_t resolve_cell(input cell_item_t it);
    entry_result_t r;
    logic [SNUM_W-1:0] smp;
    logic [PARAM_W-1:0] prm;
    int lim;
    int start;
    r = '0;
    if (it.op == OP_LOAD) begin
      desc_used[it.sample_number] = it.used_len;
      desc_loop_begin[it.sample_number] = it.loop_begin;
      desc_loop_size[it.sample_number] = it.loop_size;
      return r;
    end
    r.param = it.offset_param;
    if (it.sample_number != 0)
      chan_sample[it.channel] = it.sample_number - 1'b1;
    if (!it.is_offset_effect)
      return r;
    smp = chan_sample[it.channel];
    prm = (it.offset_param == 0) ? chan_offset[it.channel] : it.offset_param;
    chan_offset[it.channel] = prm;
    r.param = prm;
    for (int k = 0; k < key_count; k++) begin
      if (key_sample[k] == smp && key_param[k] == prm) begin
        r.is_subsample = 1'b1;
        r.param = PARAM_W'(k);
        return r;
      end
    end
    lim = (capacity < DEF_ENTRIES) ? int'(capacity) : DEF_ENTRIES;
    if (key_count >= lim)
      return r;
    start = int'(prm) * 256;
    if (start > int'(desc_used[smp]))
      start = int'(desc_used[smp]);
    key_sample[key_count] = smp;
    key_param[key_count] = prm;
    r.is_subsample = 1'b1;
    r.param = PARAM_W'(key_count);
    r.new_entry = 1'b1;
    r.sample = smp;
    r.start = LEN_W'(start);
    r.length = desc_used[smp] - LEN_W'(start);
    if (desc_loop_size[smp] > LOOP_MIN_LEN && start <= int'(desc_loop_begin[smp])) begin
      r.lp_start = desc_loop_begin[smp] - LEN_W'(start);
      r.lp_len = desc_loop_size[smp];
    end
    key_count++;
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] rand_length();
    case ($urandom_range(5))
      0: return '0;
      1: return LEN_W'(LEN_MAX);
      2: return LEN_W'($urandom_range(4));
      3: return LEN_W'($urandom_range(16'hFFFF));
      default: return LEN_W'($urandom_range(LEN_MAX));
    endcase
  endfunction

  function automatic cell_item_t make_item(input int gap, input int stall);
    cell_item_t it;
    int pick;
    it = '0;
    it.gap_pct = 7'(gap);
    it.stall_pct = 7'(stall);
    it.channel = CHAN_W'($urandom_range(DEF_CHANNELS - 1));
    it.offset_param = PARAM_W'($urandom);
    it.used_len = rand_length();
    it.loop_begin = rand_length();
    it.loop_size = rand_length();
    it.is_offset_effect = 1'($urandom_range(1));
    if ($urandom_range(99) < 20) begin
      it.op = OP_LOAD;
      it.sample_number = SNUM_W'(($urandom_range(99) < 70) ? $urandom_range(3)
                                                            : $urandom_range(DEF_SAMPLES - 1));
      desc_loaded[it.sample_number] = 1'b1;
      return it;
    end
    it.op = OP_CELL;
    it.is_offset_effect = ($urandom_range(99) < 75);
    pick = int'(($urandom_range(99) < 70) ? $urandom_range(3)
                                          : $urandom_range(DEF_SAMPLES - 2));
    // keep every channel on a sample whose descriptor is loaded
    it.sample_number = SNUM_W'(($urandom_range(99) < 40 || !desc_loaded[pick]) ? 0 : pick + 1);
    case ($urandom_range(9))
      0, 1, 2: it.offset_param = '0;
      3, 4, 5, 6: it.offset_param = PARAM_W'(($urandom_range(3) == 3) ? 8'h80
                                                                      : $urandom_range(3, 1));
      7: it.offset_param = 8'hFF;
      default: it.offset_param = PARAM_W'($urandom);
    endcase
    return it;
  endfunction

  task automatic push_load(input int idx, input int used, input int lbeg, input int lsize);
    cell_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.sample_number = SNUM_W'(idx);
    it.used_len = LEN_W'(used);
    it.loop_begin = LEN_W'(lbeg);
    it.loop_size = LEN_W'(lsize);
    desc_loaded[idx] = 1'b1;
    pending_cells.push_back(it);
  endtask

  task automatic push_cell(input int ch, input int snum, input bit offset, input int prm);
    cell_item_t it;
    it = '0;
    it.op = OP_CELL;
    it.channel = CHAN_W'(ch);
    it.sample_number = SNUM_W'(snum);
    it.is_offset_effect = offset;
    it.offset_param = PARAM_W'(prm);
    pending_cells.push_back(it);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_cells.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_max_entries <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1)
      @(posedge clk);
    capacity = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cap);
    int gap;
    int stall;
    set_capacity(cap);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      case ((n / 21) % 4)
        0: begin gap = 0;  stall = 0;  end
        1: begin gap = 56; stall = 0;  end
        2: begin gap = 0;  stall = 56; end
        default: begin gap = 16; stall = 16; end
      endcase
      pending_cells.push_back(make_item(gap, stall));
    end
    drain();
  endtask

  task automatic check_result(input entry_result_t want);
    entry_result_t got;
    got = {out_is_subsample, out_param, out_new_entry, out_entry_sample, out_entry_start,
           out_entry_length, out_entry_loop_start, out_entry_loop_length};
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("mismatch: expected sub=%0d param=%0d new=%0d smp=%0d start=%0d len=%0d ls=%0d ll=%0d",
                 want.is_subsample, want.param, want.new_entry, want.sample, want.start,
                 want.length, want.lp_start, want.lp_len,
                 "\n          actual   sub=%0d param=%0d new=%0d smp=%0d start=%0d len=%0d ls=%0d ll=%0d",
                 got.is_subsample, got.param, got.new_entry, got.sample, got.start,
                 got.length, got.lp_start, got.lp_len);
    end
  endtask

  always @(posedge clk) begin
    if (in_valid && in_ready)
      expected_results.push_back(resolve_cell(pending_cells.pop_front()));
    if (!(in_valid && !in_ready)) begin
      if (pending_cells.size() != 0 && $urandom_range(99) >= pending_cells[0].gap_pct) begin
        in_valid <= 1'b1;
        in_op <= pending_cells[0].op;
        in_channel <= pending_cells[0].channel;
        in_sample_number <= pending_cells[0].sample_number;
        in_is_offset_effect <= pending_cells[0].is_offset_effect;
        in_offset_param <= pending_cells[0].offset_param;
        in_used_length <= pending_cells[0].used_len;
        in_loop_begin <= pending_cells[0].loop_begin;
        in_loop_size <= pending_cells[0].loop_size;
        stall_pct <= pending_cells[0].stall_pct;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result transfer: sub=%0d param=%0d new=%0d",
                   out_is_subsample, out_param, out_new_entry);
      end else begin
        check_result(expected_results.pop_front());
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < DEF_CHANNELS; c++) begin
      chan_sample[c] = '0;
      chan_offset[c] = '0;
    end
    key_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_capacity(7'h7F);

    push_load(0, LEN_MAX, 'h1000, LEN_MAX);
    push_load(1, 'h300, 'h100, 3);
    push_load(2, 0, 0, 0);
    push_load(30, 'h5000, 'h800, 2);
    push_load(31, LEN_MAX, LEN_MAX, LEN_MAX);
    push_cell(0, 0, 1'b1, 0);
    push_cell(0, 1, 1'b1, 0);
    push_cell(1, 2, 1'b1, 2);
    push_cell(1, 0, 1'b1, 1);
    push_cell(1, 0, 1'b1, 0);
    push_cell(2, 3, 1'b1, 'hFF);
    push_cell(7, 31, 1'b1, 'hFF);
    push_cell(7, 31, 1'b0, 'hAB);
    push_cell(3, 2, 1'b0, 'hFF);
    push_cell(3, 0, 1'b1, 0);
    push_cell(6, 0, 1'b1, 'h80);
    push_cell(4, 0, 1'b0, 0);
    push_load(0, 'h40, 'h10, 'h20);
    push_cell(5, 1, 1'b1, 3);
    drain();

    run_phase(7'd0);
    run_phase(7'd20);
    run_phase(7'd40);
    run_phase(7'h7F);
    run_phase(MAX_ENTRIES_RST);

    repeat (80) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
